// File: hdl/adbds_pkg.sv
// Shared types and constants of the asymmetric debounce block with duty statistics.
`timescale 1ns / 1ps
`default_nettype none
package adbds_pkg;

	localparam int unsigned SAMPLE_PERIOD_MS_DEF = 10;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned DELAY_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = DELAY_W;
	localparam int unsigned IN_TDATA_W = 8;
	localparam int unsigned OUT_FIELDS_W = 2 + 3 * TIME_W;
	localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_RISE_DELAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_DELAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_LEVEL = 2'd2;

	localparam logic [DELAY_W-1:0] RISE_DELAY_RST = 16'd2000;
	localparam logic [DELAY_W-1:0] FALL_DELAY_RST = 16'd3000;
	localparam logic INIT_LEVEL_RST = 1'b0;

	typedef struct packed {
		logic op;
		logic level;
	} item_t;

	typedef struct packed {
		logic                we;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic              status;
		logic              changed;
		logic [TIME_W-1:0] on_total;
		logic [TIME_W-1:0] off_total;
		logic [TIME_W-1:0] stamp;
		logic [TIME_W-1:0] now;
	} snap_t;

endpackage
`default_nettype wire

// File: hdl/asymmetric_debounce_with_duty_stats.sv
// Top level of the asymmetric debounce filter with on and off time statistics.
//
//  channel  direction  beat contents
//  s_*      in         tuser: op; tdata: line_level
//  m_*      out        tdata: status, changed, on_time_ms, off_time_ms, last_change_ms
//  cfg_*    in         write enable, register index, write data
//
// One beat is accepted per cycle unless a stalled result backs up the stages; a beat passes
// from the input register to the state update, whose snapshot register fills the result register.
// The state update compares the elapsed time with the delay and uses 32-bit subtracts and adds.
// Reset loads the register defaults at once; no clearing pass is needed.
// A stalled result holds each stage in place and a stage with a bubble still takes a beat.
`timescale 1ns / 1ps
`default_nettype none
module asymmetric_debounce_with_duty_stats #(
	parameter int unsigned SAMPLE_PERIOD_MS = adbds_pkg::SAMPLE_PERIOD_MS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// Bit 0: line_level; upper bits zero.
	input  wire  [adbds_pkg::IN_TDATA_W-1:0]    s_tdata,
	// Bit 0: op.
	input  wire                                 s_tuser,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// From bit 0: status, changed, on_time_ms, off_time_ms, last_change_ms, zero fill.
	output logic [adbds_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  wire                                 cfg_we,
	input  wire  [adbds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [adbds_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic               v_s1, ready_s2, v_s2, out_ready;
	adbds_pkg::item_t   item_s1;
	adbds_pkg::snap_t   snap_s2;
	adbds_pkg::cfg_wr_t cfg;

	assign s_tready = !v_s1 || ready_s2;
	assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op <= s_tuser;
			item_s1.level <= s_tdata[0];
		end
	end

	adbds_core #(
		.SAMPLE_PERIOD_MS(SAMPLE_PERIOD_MS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.v_s1     (v_s1),
		.item_s1  (item_s1),
		.out_ready(out_ready),
		.ready_s2 (ready_s2),
		.v_s2     (v_s2),
		.snap_s2  (snap_s2)
	);

	adbds_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s2     (v_s2),
		.snap_s2  (snap_s2),
		.out_ready(out_ready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

	// A status change restarts the session, so its stamp is the current clock.
	a_change_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && snap_s2.changed |-> snap_s2.stamp == snap_s2.now)
		else $error("status change without matching stamp");

	// A clear command never reports a status change.
	a_clear_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && ready_s2 && (item_s1.op == adbds_pkg::OP_CLEAR) |=> v_s2 && !snap_s2.changed)
		else $error("clear command reported a change");

	// A beat held in the input register while the next stage is busy stays put.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !ready_s2 |=> v_s1 && $stable(item_s1))
		else $error("input register lost a stalled beat");

	// The result register only loads when a snapshot is waiting.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready && !v_s2 |=> !m_tvalid)
		else $error("result shown without a snapshot");

endmodule
`default_nettype wire

// File: hdl/adbds_core.sv
// Debounce state and duty totals, updated once per beat, and configuration registers, written when no beat advances.
`timescale 1ns / 1ps
`default_nettype none
module adbds_core #(
	parameter int unsigned SAMPLE_PERIOD_MS = adbds_pkg::SAMPLE_PERIOD_MS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  adbds_pkg::cfg_wr_t    cfg,
	input  wire                   v_s1,
	input  adbds_pkg::item_t      item_s1,
	input  wire                   out_ready,
	output logic                  ready_s2,
	output logic                  v_s2,
	output adbds_pkg::snap_t      snap_s2
);

	localparam logic [adbds_pkg::TIME_W-1:0] PERIOD = adbds_pkg::TIME_W'(SAMPLE_PERIOD_MS);

	logic [adbds_pkg::DELAY_W-1:0] rise_q, fall_q;
	logic [adbds_pkg::TIME_W-1:0]  now_q, nxt_q, ws_q, on_q, off_q, stamp_q;
	logic                          last_q, pend_q, tgt_q, qual_q;

	logic                          advance, tick, lvl_chg, pend_a, tgt_a, fire, do_chg;
	logic [adbds_pkg::DELAY_W-1:0] need;
	logic [adbds_pkg::TIME_W-1:0]  elapsed, now_n, dur, on_n, off_n, stamp_n;
	logic                          qual_n, last_n, pend_n;

	assign ready_s2 = !v_s2 || out_ready;
	assign advance = v_s1 && ready_s2;

	always_comb begin
		tick = (item_s1.op == adbds_pkg::OP_TICK);
		lvl_chg = tick && (item_s1.level != last_q);
		pend_a = pend_q || lvl_chg;
		tgt_a = lvl_chg ? item_s1.level : tgt_q;
		need = tgt_a ? rise_q : fall_q;
		elapsed = lvl_chg ? '0 : (nxt_q - ws_q);
		fire = tick && pend_a &&
			((need == '0) || (elapsed >= {{(adbds_pkg::TIME_W-adbds_pkg::DELAY_W){1'b0}}, need}));
		do_chg = fire && (item_s1.level == tgt_a) && (qual_q != tgt_a);
		now_n = tick ? nxt_q : now_q;
		dur = now_n - stamp_q;
		on_n = on_q;
		off_n = off_q;
		stamp_n = stamp_q;
		qual_n = qual_q;
		last_n = lvl_chg ? item_s1.level : last_q;
		pend_n = fire ? 1'b0 : pend_a;
		if (!tick) begin
			on_n = '0;
			off_n = '0;
			stamp_n = now_q;
			pend_n = pend_q;
		end else if (do_chg) begin
			if (qual_q) begin
				on_n = on_q + dur;
			end else begin
				off_n = off_q + dur;
			end
			qual_n = tgt_a;
			stamp_n = now_n;
		end else if (fire && (item_s1.level != tgt_a)) begin
			last_n = item_s1.level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q <= adbds_pkg::RISE_DELAY_RST;
			fall_q <= adbds_pkg::FALL_DELAY_RST;
			now_q <= '0;
			nxt_q <= PERIOD;
			ws_q <= '0;
			last_q <= adbds_pkg::INIT_LEVEL_RST;
			pend_q <= 1'b0;
			tgt_q <= 1'b0;
			qual_q <= adbds_pkg::INIT_LEVEL_RST;
			on_q <= '0;
			off_q <= '0;
			stamp_q <= '0;
			v_s2 <= 1'b0;
		end else begin
			if (advance) begin
				v_s2 <= 1'b1;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
			if (advance) begin
				if (tick) begin
					now_q <= nxt_q;
					nxt_q <= nxt_q + PERIOD;
				end
				if (lvl_chg) begin
					ws_q <= nxt_q;
				end
				tgt_q <= tgt_a;
				last_q <= last_n;
				pend_q <= pend_n;
				qual_q <= qual_n;
				on_q <= on_n;
				off_q <= off_n;
				stamp_q <= stamp_n;
			end else if (cfg.we) begin
				case (cfg.index)
					adbds_pkg::REG_RISE_DELAY: begin
						rise_q <= cfg.data;
						pend_q <= 1'b0;
					end
					adbds_pkg::REG_FALL_DELAY: begin
						fall_q <= cfg.data;
						pend_q <= 1'b0;
					end
					adbds_pkg::REG_INIT_LEVEL: begin
						qual_q <= cfg.data[0];
						last_q <= cfg.data[0];
						pend_q <= 1'b0;
						stamp_q <= now_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			snap_s2.status <= qual_n;
			snap_s2.changed <= do_chg;
			snap_s2.on_total <= on_n;
			snap_s2.off_total <= off_n;
			snap_s2.stamp <= stamp_n;
			snap_s2.now <= now_n;
		end
	end

endmodule
`default_nettype wire

// File: hdl/adbds_out.sv
// Result stage: adds the running session to the totals and holds the output beat.
`timescale 1ns / 1ps
`default_nettype none
module adbds_out (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                v_s2,
	input  adbds_pkg::snap_t                   snap_s2,
	output logic                               out_ready,
	input  wire                                m_tready,
	output logic                               m_tvalid,
	output logic [adbds_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	logic [adbds_pkg::TIME_W-1:0] session, on_t, off_t;
	logic [adbds_pkg::OUT_TDATA_W-1:0] tdata_q;

	assign out_ready = !m_tvalid || m_tready;

	always_comb begin
		session = snap_s2.now - snap_s2.stamp;
		on_t = snap_s2.on_total + (snap_s2.status ? session : '0);
		off_t = snap_s2.off_total + (snap_s2.status ? '0 : session);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_ready) begin
			m_tvalid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && v_s2) begin
			tdata_q <= {{(adbds_pkg::OUT_TDATA_W-adbds_pkg::OUT_FIELDS_W){1'b0}},
				snap_s2.stamp, off_t, on_t, snap_s2.changed, snap_s2.status};
		end
	end

	assign m_tdata = tdata_q;

endmodule
`default_nettype wire
